[rtl/julian_gregorian_date_unit_core_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the calendar date unit
// Wrappers that sample on clk and stay quiet while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef JULIAN_GREGORIAN_DATE_UNIT_CORE_ASSERT_SVH
`define JULIAN_GREGORIAN_DATE_UNIT_CORE_ASSERT_SVH

// same-cycle implication
`define JGDU_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define JGDU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/jgdu_pkg.sv]
// ----------------------------------------------------------------------------
// jgdu_pkg
// Types, calendar constants and month tables shared by the date unit.
// ----------------------------------------------------------------------------
package jgdu_pkg;

  localparam int unsigned MAX_YEAR     = 9999;
  localparam int unsigned CUTOVER_YEAR = 1582;
  localparam int unsigned YEAR_LIMIT   = (MAX_YEAR > 16383) ? 16383 : MAX_YEAR;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int DN_W    = 22;
  localparam int DNX_W   = 23;
  localparam int WD_W    = 3;
  localparam int DIFF_W  = 23;
  localparam int PART_W  = 13;

  typedef logic [YEAR_W-1:0]  year_t;
  typedef logic [MONTH_W-1:0] month_t;
  typedef logic [DAY_W-1:0]   day_t;
  typedef logic [DNX_W-1:0]   dnx_t;
  typedef logic [WD_W-1:0]    wd_t;

  typedef enum logic [1:0] {
    KIND_LOAD = 2'd0,
    KIND_NEXT = 2'd1,
    KIND_PREV = 2'd2,
    KIND_DIFF = 2'd3
  } kind_t;

  typedef struct packed {
    logic leap;
    dnx_t dn;
    wd_t  wd;
  } dninfo_t;

  localparam year_t  FIRST_YEAR     = year_t'(1);
  localparam year_t  CUT_Y          = year_t'(CUTOVER_YEAR);
  localparam year_t  LIMIT_Y        = year_t'(YEAR_LIMIT);
  localparam month_t MONTH_JAN      = month_t'(1);
  localparam month_t MONTH_FEB      = month_t'(2);
  localparam month_t MONTH_OCT      = month_t'(10);
  localparam month_t MONTH_DEC      = month_t'(12);
  localparam day_t   DAY_FIRST      = day_t'(1);
  localparam day_t   DEC_LAST_DAY   = day_t'(31);
  localparam day_t   DAY_BEFORE_GAP = day_t'(4);
  localparam day_t   GAP_FIRST_DAY  = day_t'(5);
  localparam day_t   GAP_LAST_DAY   = day_t'(14);
  localparam day_t   DAY_AFTER_GAP  = day_t'(15);

  localparam int GAP_DAYS          = 10;
  localparam int DAYS_PER_YEAR     = 365;
  localparam int DAYS_PER_WEEK     = 7;
  localparam int WEEKDAY_OFS       = 5;
  localparam int YEARS_PER_CENTURY = 100;
  localparam int GREG_ADJ          = (CUTOVER_YEAR - 1) / 100 - (CUTOVER_YEAR - 1) / 400;

  // floor(x/100) = (x*DIV100_MUL) >> DIV100_SHIFT for x < 2^14
  localparam int DIV100_MUL   = 10486;
  localparam int DIV100_SHIFT = 20;
  // floor(x/7) = (x*DIV7_MUL) >> DIV7_SHIFT for x < 6.7e6
  localparam int DIV7_MUL     = 4793491;
  localparam int DIV7_SHIFT   = 25;

  localparam wd_t WD_RESET = wd_t'((1 + WEEKDAY_OFS) % DAYS_PER_WEEK);

  function automatic day_t month_len(input logic leap, input month_t m);
    day_t len;
    case (m)
      4'd2:                               len = leap ? day_t'(29) : day_t'(28);
      4'd4, 4'd6, 4'd9, 4'd11:            len = day_t'(30);
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = day_t'(31);
      default:                            len = '0;
    endcase
    return len;
  endfunction

  // days in the months before m, leap day included
  function automatic logic [8:0] prefix_days(input logic leap, input month_t m);
    logic [8:0] base;
    case (m)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd0;
      4'd2:    base = 9'd31;
      4'd3:    base = 9'd59;
      4'd4:    base = 9'd90;
      4'd5:    base = 9'd120;
      4'd6:    base = 9'd151;
      4'd7:    base = 9'd181;
      4'd8:    base = 9'd212;
      4'd9:    base = 9'd243;
      4'd10:   base = 9'd273;
      4'd11:   base = 9'd304;
      4'd12:   base = 9'd334;
      default: base = 9'd365;
    endcase
    return base + ((leap && (m > MONTH_FEB)) ? 9'd1 : 9'd0);
  endfunction

endpackage

[rtl/jgdu_daynum.sv]
// ----------------------------------------------------------------------------
// jgdu_daynum
// Day number, leap flag and weekday of one date, sequenced through a single
// shared multiplier: quotient by 100, years times 365, quotient by 7.
// ----------------------------------------------------------------------------
module jgdu_daynum (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  jgdu_pkg::year_t   year_i,
  input  jgdu_pkg::month_t  month_i,
  input  jgdu_pkg::day_t    day_i,
  output logic              done,
  output jgdu_pkg::dninfo_t info
);

  localparam int MUL_W = jgdu_pkg::DNX_W;

  typedef enum logic [5:0] {
    U_IDLE = 6'b000001,
    U_QUO  = 6'b000010,
    U_YEAR = 6'b000100,
    U_SUM  = 6'b001000,
    U_MULW = 6'b010000,
    U_WDAY = 6'b100000
  } ustate_t;

  ustate_t                      ustate_r, ustate_nxt;
  logic                         done_r;
  jgdu_pkg::year_t              y_r;
  jgdu_pkg::month_t             m_r;
  jgdu_pkg::day_t               d_r;
  logic [2*MUL_W-1:0]           mul_r;
  logic [MUL_W-1:0]             mul_a, mul_b;
  logic [jgdu_pkg::PART_W-1:0]  part_r, part_nxt, leaps;
  logic                         leap_r, leap_nxt;
  jgdu_pkg::dnx_t               dn_r;
  jgdu_pkg::wd_t                wd_r, wd_nxt;
  jgdu_pkg::year_t              ym1, h100, r100;
  logic [7:0]                   q100, qm1;
  logic                         r_zero, gap_after;
  logic [2:0]                   xlo, q7lo;

  always_comb begin
    unique case (ustate_r)
      U_IDLE:  ustate_nxt = start ? U_QUO : U_IDLE;
      U_QUO:   ustate_nxt = U_YEAR;
      U_YEAR:  ustate_nxt = U_SUM;
      U_SUM:   ustate_nxt = U_MULW;
      U_MULW:  ustate_nxt = U_WDAY;
      U_WDAY:  ustate_nxt = U_IDLE;
      default: ustate_nxt = U_IDLE;
    endcase
  end

  assign ym1 = y_r - jgdu_pkg::FIRST_YEAR;

  always_comb begin
    unique case (ustate_r)
      U_QUO: begin
        mul_a = MUL_W'(y_r);
        mul_b = MUL_W'(jgdu_pkg::DIV100_MUL);
      end
      U_YEAR: begin
        mul_a = MUL_W'(ym1);
        mul_b = MUL_W'(jgdu_pkg::DAYS_PER_YEAR);
      end
      U_MULW: begin
        mul_a = dn_r + MUL_W'(jgdu_pkg::WEEKDAY_OFS);
        mul_b = MUL_W'(jgdu_pkg::DIV7_MUL);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    q100   = mul_r[jgdu_pkg::DIV100_SHIFT +: 8];
    h100   = jgdu_pkg::YEAR_W'(q100) * jgdu_pkg::YEAR_W'(jgdu_pkg::YEARS_PER_CENTURY);
    r100   = y_r - h100;
    r_zero = (r100 == '0);
    qm1    = q100 - 8'(r_zero);
    if (y_r < jgdu_pkg::CUT_Y) begin
      leap_nxt = (y_r[1:0] == 2'b00);
      leaps    = jgdu_pkg::PART_W'(ym1 >> 2);
    end else begin
      leap_nxt = ((y_r[1:0] == 2'b00) && !r_zero) || (r_zero && (q100[1:0] == 2'b00));
      leaps    = jgdu_pkg::PART_W'(ym1 >> 2) - jgdu_pkg::PART_W'(qm1)
               + jgdu_pkg::PART_W'(qm1 >> 2) + jgdu_pkg::PART_W'(jgdu_pkg::GREG_ADJ);
    end
    gap_after = (y_r > jgdu_pkg::CUT_Y) ||
                ((y_r == jgdu_pkg::CUT_Y) && ((m_r > jgdu_pkg::MONTH_OCT) ||
                 ((m_r == jgdu_pkg::MONTH_OCT) && (d_r >= jgdu_pkg::DAY_AFTER_GAP))));
    part_nxt  = leaps + jgdu_pkg::PART_W'(jgdu_pkg::prefix_days(leap_nxt, m_r))
              + jgdu_pkg::PART_W'(d_r)
              - (gap_after ? jgdu_pkg::PART_W'(jgdu_pkg::GAP_DAYS) : '0);
  end

  always_comb begin
    xlo    = dn_r[2:0] + 3'(jgdu_pkg::WEEKDAY_OFS);
    q7lo   = mul_r[jgdu_pkg::DIV7_SHIFT +: 3];
    wd_nxt = xlo - 3'(q7lo * 3'(jgdu_pkg::DAYS_PER_WEEK));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ustate_r <= U_IDLE;
      done_r   <= 1'b0;
    end else begin
      ustate_r <= ustate_nxt;
      done_r   <= (ustate_r == U_WDAY);
    end
  end

  always_ff @(posedge clk) begin
    if ((ustate_r == U_IDLE) && start) begin
      y_r <= year_i;
      m_r <= month_i;
      d_r <= day_i;
    end
    if ((ustate_r == U_QUO) || (ustate_r == U_YEAR) || (ustate_r == U_MULW)) begin
      mul_r <= mul_a * mul_b;
    end
    if (ustate_r == U_YEAR) begin
      leap_r <= leap_nxt;
      part_r <= part_nxt;
    end
    if (ustate_r == U_SUM) begin
      dn_r <= mul_r[MUL_W-1:0] + MUL_W'(part_r);
    end
    if (ustate_r == U_WDAY) begin
      wd_r <= wd_nxt;
    end
  end

  assign done      = done_r;
  assign info.leap = leap_r;
  assign info.dn   = dn_r;
  assign info.wd   = wd_r;

endmodule

[rtl/julian_gregorian_date_unit_core.sv]
// ----------------------------------------------------------------------------
// julian_gregorian_date_unit_core
// Holds one calendar date (Julian leap rules before 1582, Gregorian from 1582,
// 1582-10-05 to 1582-10-14 absent) and per item loads a checked date, steps
// one day forward or back, or takes the signed day difference to a given
// date; every result carries the date, its day number, weekday and an error
// flag. The block takes one item at a time and holds in_stall high while it
// works. Each date is run through the day-number unit, which pushes it three
// times through one shared multiplier (by 100, by 365, by 7); a refused
// step skips that unit.
// A finished result waits in the output register while the next item is
// taken.
// ----------------------------------------------------------------------------
`include "julian_gregorian_date_unit_core_assert.svh"

module julian_gregorian_date_unit_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_kind,
  input  logic [13:0]         in_year_in,
  input  logic [3:0]          in_month_in,
  input  logic [4:0]          in_day_in,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [13:0]         out_year_out,
  output logic [3:0]          out_month_out,
  output logic [4:0]          out_day_out,
  output logic [21:0]         out_day_number,
  output logic [2:0]          out_weekday,
  output logic signed [22:0]  out_difference,
  output logic                out_error
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_GSTART = 7'b0000010,
    S_GWAIT  = 7'b0000100,
    S_STEP   = 7'b0001000,
    S_SSTART = 7'b0010000,
    S_SWAIT  = 7'b0100000,
    S_FIN    = 7'b1000000
  } state_t;

  state_t                    state_r, state_nxt;
  jgdu_pkg::kind_t           kind_r, in_kind_k;

  jgdu_pkg::year_t           cur_year_r;
  jgdu_pkg::month_t          cur_month_r;
  jgdu_pkg::day_t            cur_day_r;
  logic                      cur_leap_r;
  jgdu_pkg::dnx_t            cur_dn_r;
  jgdu_pkg::wd_t             cur_wd_r;

  jgdu_pkg::year_t           g_year_r;
  jgdu_pkg::month_t          g_month_r;
  jgdu_pkg::day_t            g_day_r;

  jgdu_pkg::year_t           nxt_year_r, step_year;
  jgdu_pkg::month_t          nxt_month_r, step_month;
  jgdu_pkg::day_t            nxt_day_r, step_day;
  logic                      step_err;

  logic [jgdu_pkg::DIFF_W-1:0] diff_r;
  logic                        err_r;

  logic                      out_valid_r;
  jgdu_pkg::year_t           out_year_r;
  jgdu_pkg::month_t          out_month_r;
  jgdu_pkg::day_t            out_day_r;
  logic [jgdu_pkg::DN_W-1:0] out_dn_r;
  jgdu_pkg::wd_t             out_wd_r;
  logic [jgdu_pkg::DIFF_W-1:0] out_diff_r;
  logic                      out_err_r;

  logic                      u_start, u_done;
  jgdu_pkg::year_t           u_year;
  jgdu_pkg::month_t          u_month;
  jgdu_pkg::day_t            u_day;
  jgdu_pkg::dninfo_t         u_info;

  logic                      in_xfer, g_fin, s_fin, g_ok, commit_load, out_load;

  assign in_kind_k   = jgdu_pkg::kind_t'(in_kind);
  assign in_stall    = (state_r != S_IDLE);
  assign in_xfer     = in_valid && !in_stall;
  assign g_fin       = (state_r == S_GWAIT) && u_done;
  assign s_fin       = (state_r == S_SWAIT) && u_done;
  assign out_load    = (state_r == S_FIN) && (!out_valid_r || !out_stall);

  assign g_ok = (g_year_r != '0) && (g_year_r <= jgdu_pkg::LIMIT_Y) &&
                (g_month_r >= jgdu_pkg::MONTH_JAN) && (g_month_r <= jgdu_pkg::MONTH_DEC) &&
                (g_day_r != '0) &&
                !((g_year_r == jgdu_pkg::CUT_Y) && (g_month_r == jgdu_pkg::MONTH_OCT) &&
                  (g_day_r >= jgdu_pkg::GAP_FIRST_DAY) && (g_day_r <= jgdu_pkg::GAP_LAST_DAY)) &&
                (g_day_r <= jgdu_pkg::month_len(u_info.leap, g_month_r));

  assign commit_load = g_fin && g_ok && (kind_r == jgdu_pkg::KIND_LOAD);

  assign u_start = (state_r == S_GSTART) || (state_r == S_SSTART);
  assign u_year  = (state_r == S_SSTART) ? nxt_year_r  : g_year_r;
  assign u_month = (state_r == S_SSTART) ? nxt_month_r : g_month_r;
  assign u_day   = (state_r == S_SSTART) ? nxt_day_r   : g_day_r;

  jgdu_daynum u_daynum (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (u_start),
    .year_i  (u_year),
    .month_i (u_month),
    .day_i   (u_day),
    .done    (u_done),
    .info    (u_info)
  );

  function automatic jgdu_pkg::month_t month_t_one();
    return jgdu_pkg::MONTH_JAN;
  endfunction

  always_comb begin
    step_year  = cur_year_r;
    step_month = cur_month_r;
    step_day   = cur_day_r;
    step_err   = 1'b0;
    if (kind_r == jgdu_pkg::KIND_NEXT) begin
      if ((cur_year_r == jgdu_pkg::CUT_Y) && (cur_month_r == jgdu_pkg::MONTH_OCT) &&
          (cur_day_r == jgdu_pkg::DAY_BEFORE_GAP)) begin
        step_day = jgdu_pkg::DAY_AFTER_GAP;
      end else if (cur_day_r >= jgdu_pkg::month_len(cur_leap_r, cur_month_r)) begin
        step_day = jgdu_pkg::DAY_FIRST;
        if (cur_month_r == jgdu_pkg::MONTH_DEC) begin
          step_month = jgdu_pkg::MONTH_JAN;
          if (cur_year_r >= jgdu_pkg::LIMIT_Y) begin
            step_err = 1'b1;
          end else begin
            step_year = cur_year_r + jgdu_pkg::FIRST_YEAR;
          end
        end else begin
          step_month = cur_month_r + month_t_one();
        end
      end else begin
        step_day = cur_day_r + jgdu_pkg::DAY_FIRST;
      end
    end else begin
      if ((cur_year_r == jgdu_pkg::CUT_Y) && (cur_month_r == jgdu_pkg::MONTH_OCT) &&
          (cur_day_r == jgdu_pkg::DAY_AFTER_GAP)) begin
        step_day = jgdu_pkg::DAY_BEFORE_GAP;
      end else if ((cur_day_r == jgdu_pkg::DAY_FIRST) &&
                   (cur_month_r == jgdu_pkg::MONTH_JAN)) begin
        if (cur_year_r <= jgdu_pkg::FIRST_YEAR) begin
          step_err = 1'b1;
        end else begin
          step_year  = cur_year_r - jgdu_pkg::FIRST_YEAR;
          step_month = jgdu_pkg::MONTH_DEC;
          step_day   = jgdu_pkg::DEC_LAST_DAY;
        end
      end else if (cur_day_r == jgdu_pkg::DAY_FIRST) begin
        step_month = cur_month_r - month_t_one();
        step_day   = jgdu_pkg::month_len(cur_leap_r, cur_month_r - month_t_one());
      end else begin
        step_day = cur_day_r - jgdu_pkg::DAY_FIRST;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = ((in_kind_k == jgdu_pkg::KIND_LOAD) ||
                       (in_kind_k == jgdu_pkg::KIND_DIFF)) ? S_GSTART : S_STEP;
        end
      end
      S_GSTART: state_nxt = S_GWAIT;
      S_GWAIT:  state_nxt = u_done ? S_FIN : S_GWAIT;
      S_STEP:   state_nxt = step_err ? S_FIN : S_SSTART;
      S_SSTART: state_nxt = S_SWAIT;
      S_SWAIT:  state_nxt = u_done ? S_FIN : S_SWAIT;
      S_FIN:    state_nxt = out_load ? S_IDLE : S_FIN;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_year_r  <= jgdu_pkg::FIRST_YEAR;
      cur_month_r <= jgdu_pkg::MONTH_JAN;
      cur_day_r   <= jgdu_pkg::DAY_FIRST;
      cur_leap_r  <= 1'b0;
      cur_dn_r    <= jgdu_pkg::dnx_t'(1);
      cur_wd_r    <= jgdu_pkg::WD_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (commit_load) begin
        cur_year_r  <= g_year_r;
        cur_month_r <= g_month_r;
        cur_day_r   <= g_day_r;
        cur_leap_r  <= u_info.leap;
        cur_dn_r    <= u_info.dn;
        cur_wd_r    <= u_info.wd;
      end else if (s_fin) begin
        cur_year_r  <= nxt_year_r;
        cur_month_r <= nxt_month_r;
        cur_day_r   <= nxt_day_r;
        cur_leap_r  <= u_info.leap;
        cur_dn_r    <= u_info.dn;
        cur_wd_r    <= u_info.wd;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      kind_r    <= in_kind_k;
      g_year_r  <= in_year_in;
      g_month_r <= in_month_in;
      g_day_r   <= in_day_in;
      diff_r    <= '0;
      err_r     <= 1'b0;
    end
    if (g_fin) begin
      if (!g_ok) begin
        err_r <= 1'b1;
      end else if (kind_r == jgdu_pkg::KIND_DIFF) begin
        diff_r <= cur_dn_r - u_info.dn;
      end
    end
    if (state_r == S_STEP) begin
      nxt_year_r  <= step_year;
      nxt_month_r <= step_month;
      nxt_day_r   <= step_day;
      err_r       <= step_err;
    end
    if (out_load) begin
      out_year_r  <= cur_year_r;
      out_month_r <= cur_month_r;
      out_day_r   <= cur_day_r;
      out_dn_r    <= cur_dn_r[jgdu_pkg::DN_W-1:0];
      out_wd_r    <= cur_wd_r;
      out_diff_r  <= diff_r;
      out_err_r   <= err_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_year_out   = out_year_r;
  assign out_month_out  = out_month_r;
  assign out_day_out    = out_day_r;
  assign out_day_number = out_dn_r;
  assign out_weekday    = out_wd_r;
  assign out_difference = $signed(out_diff_r);
  assign out_error      = out_err_r;

  `JGDU_ASSERT_NEXT(a_busy_after_transfer, in_valid && !in_stall, in_stall, "input taken while busy")
  `JGDU_ASSERT_IMPL(a_date_valid, 1'b1, (cur_year_r != '0) && (cur_year_r <= jgdu_pkg::LIMIT_Y) && (cur_month_r >= jgdu_pkg::MONTH_JAN) && (cur_month_r <= jgdu_pkg::MONTH_DEC) && (cur_day_r != '0) && (cur_day_r <= jgdu_pkg::month_len(cur_leap_r, cur_month_r)), "stored date invalid")
  `JGDU_ASSERT_IMPL(a_done_when_waiting, u_done, (state_r == S_GWAIT) || (state_r == S_SWAIT), "day-number unit done while not awaited")
  `JGDU_ASSERT_IMPL(a_out_from_fin, $rose(out_valid), $past(state_r == S_FIN), "result raised outside finish")

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// Calendar date unit testbench
// Drives load, next-day, previous-day and difference commands into the date
// unit, predicts every result from an independent calendar model (Julian
// before the cutover, Gregorian after, ten-day gap removed) and checks each
// result field by field. Sender idling and result stalling vary by phase.
// ----------------------------------------------------------------------------
package date_ledger_pkg;
  import jgdu_pkg::*;

  typedef struct {
    year_t       year;
    month_t      month;
    day_t        day;
    logic [21:0] day_number;
    wd_t         weekday;
    logic [22:0] difference;
    logic        error;
  } date_result_t;

  function automatic bit leap_rule(int unsigned y);
    if (y < CUTOVER_YEAR) return (y % 4) == 0;
    return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
  endfunction

  function automatic int unsigned month_span(int unsigned y, int unsigned m);
    if (m < 1 || m > 12) return 0;
    case (m)
      2:           return leap_rule(y) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  function automatic bit date_exists(int unsigned y, int unsigned m, int unsigned d);
    if (y == 0 || y > YEAR_LIMIT) return 0;
    if (m < 1 || m > 12 || d == 0) return 0;
    if (y == CUTOVER_YEAR && m == MONTH_OCT && d >= GAP_FIRST_DAY && d <= GAP_LAST_DAY)
      return 0;
    return d <= month_span(y, m);
  endfunction

  function automatic int unsigned serial_day(int unsigned y, int unsigned m, int unsigned d);
    int unsigned prior;
    int unsigned leaps;
    int unsigned dn;
    int unsigned mo;
    prior = y - 1;
    if (y < CUTOVER_YEAR) begin
      leaps = prior / 4;
    end else begin
      leaps = prior / 4 - prior / 100 + prior / 400
            + (CUTOVER_YEAR - 1) / 100 - (CUTOVER_YEAR - 1) / 400;
    end
    dn = DAYS_PER_YEAR * prior + leaps;
    if (y > CUTOVER_YEAR || (y == CUTOVER_YEAR &&
        (m > MONTH_OCT || (m == MONTH_OCT && d >= DAY_AFTER_GAP))))
      dn -= GAP_DAYS;
    for (mo = 1; mo < m; mo++) dn += month_span(y, mo);
    return dn + d;
  endfunction

  class date_ledger;
    int unsigned  cur_y;
    int unsigned  cur_m;
    int unsigned  cur_d;
    date_result_t due_dates[$];
    int unsigned  faults;
    int unsigned  checked;
    int unsigned  refused;
    int unsigned  kind_total[4];

    function new();
      cur_y = 1;
      cur_m = 1;
      cur_d = 1;
    endfunction

    function void note_command(kind_t kind, year_t gy_in, month_t gm_in, day_t gd_in);
      int unsigned  gy;
      int unsigned  gm;
      int unsigned  gd;
      int unsigned  ny;
      int unsigned  nm;
      int unsigned  nd;
      int unsigned  dn;
      int           span;
      bit           refuse;
      date_result_t res;
      gy = gy_in;
      gm = gm_in;
      gd = gd_in;
      ny = cur_y;
      nm = cur_m;
      nd = cur_d;
      span = 0;
      refuse = 0;
      kind_total[kind]++;
      case (kind)
        KIND_LOAD: begin
          if (date_exists(gy, gm, gd)) begin
            ny = gy;
            nm = gm;
            nd = gd;
          end else begin
            refuse = 1;
          end
        end
        KIND_NEXT: begin
          if (ny == CUTOVER_YEAR && nm == MONTH_OCT && nd == DAY_BEFORE_GAP) begin
            nd = DAY_AFTER_GAP;
          end else begin
            nd++;
            if (nd > month_span(ny, nm)) begin
              nd = 1;
              nm++;
            end
            if (nm > MONTH_DEC) begin
              nm = 1;
              ny++;
            end
            if (ny > YEAR_LIMIT) refuse = 1;
          end
        end
        KIND_PREV: begin
          if (ny == CUTOVER_YEAR && nm == MONTH_OCT && nd == DAY_AFTER_GAP) begin
            nd = DAY_BEFORE_GAP;
          end else if (nd == 1 && nm == 1) begin
            if (ny <= 1) begin
              refuse = 1;
            end else begin
              ny--;
              nm = MONTH_DEC;
              nd = DEC_LAST_DAY;
            end
          end else if (nd == 1) begin
            nm--;
            nd = month_span(ny, nm);
          end else begin
            nd--;
          end
        end
        default: begin
          if (date_exists(gy, gm, gd))
            span = int'(serial_day(cur_y, cur_m, cur_d)) - int'(serial_day(gy, gm, gd));
          else
            refuse = 1;
        end
      endcase
      if (!refuse) begin
        cur_y = ny;
        cur_m = nm;
        cur_d = nd;
      end else begin
        refused++;
      end
      dn = serial_day(cur_y, cur_m, cur_d);
      res.year       = year_t'(cur_y);
      res.month      = month_t'(cur_m);
      res.day        = day_t'(cur_d);
      res.day_number = 22'(dn);
      res.weekday    = wd_t'((dn + WEEKDAY_OFS) % DAYS_PER_WEEK);
      res.difference = 23'(span);
      res.error      = refuse;
      due_dates.push_back(res);
    endfunction

    function void check_result(year_t y, month_t m, day_t d, logic [21:0] dn, wd_t wd,
                               logic [22:0] diff, logic err);
      date_result_t res;
      if (due_dates.size() == 0) begin
        faults++;
        if (faults <= 10)
          $display("unexpected result %0d-%0d-%0d with nothing awaited", y, m, d);
        return;
      end
      res = due_dates.pop_front();
      checked++;
      if (y !== res.year || m !== res.month || d !== res.day || dn !== res.day_number ||
          wd !== res.weekday || diff !== res.difference || err !== res.error) begin
        faults++;
        if (faults <= 10) begin
          $display("mismatch %0d: expected %0d-%0d-%0d dn=%0d wd=%0d diff=%0d err=%0b",
                   faults, res.year, res.month, res.day, res.day_number, res.weekday,
                   $signed(res.difference), res.error);
          $display("            actual   %0d-%0d-%0d dn=%0d wd=%0d diff=%0d err=%0b",
                   y, m, d, dn, wd, $signed(diff), err);
        end
      end
    endfunction
  endclass
endpackage

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import jgdu_pkg::*;
  import date_ledger_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned TAIL_CYCLES    = 40;
  localparam int unsigned PHASE_ITEMS    = 356;
  localparam int unsigned SEND_IDLE[4]   = '{0, 81, 0, 6};
  localparam int unsigned RECV_STALL[4]  = '{0, 0, 81, 6};
  localparam int unsigned EDGE_YEARS[15] = '{1, 4, 100, 1500, 1580, 1581, 1582, 1583,
                                             1600, 1700, 1900, 2000, 2100, 9996, 9999};

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         in_kind;
  logic [13:0]        in_year_in;
  logic [3:0]         in_month_in;
  logic [4:0]         in_day_in;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [13:0]        out_year_out;
  logic [3:0]         out_month_out;
  logic [4:0]         out_day_out;
  logic [21:0]        out_day_number;
  logic [2:0]         out_weekday;
  logic signed [22:0] out_difference;
  logic               out_error;

  date_ledger  board;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned quiet_cycles = 0;

  julian_gregorian_date_unit_core u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_year_in     (in_year_in),
    .in_month_in    (in_month_in),
    .in_day_in      (in_day_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_year_out   (out_year_out),
    .out_month_out  (out_month_out),
    .out_day_out    (out_day_out),
    .out_day_number (out_day_number),
    .out_weekday    (out_weekday),
    .out_difference (out_difference),
    .out_error      (out_error)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        board.note_command(kind_t'(in_kind), in_year_in, in_month_in, in_day_in);
      if (out_valid && !out_stall)
        board.check_result(out_year_out, out_month_out, out_day_out, out_day_number,
                           out_weekday, out_difference, out_error);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("testbench: errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_cmd(kind_t k, int unsigned y, int unsigned m, int unsigned d);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_kind     <= k;
    in_year_in  <= year_t'(y);
    in_month_in <= month_t'(m);
    in_day_in   <= day_t'(d);
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_step(kind_t k);
    send_cmd(k, $urandom_range(16383), $urandom_range(15), $urandom_range(31));
  endtask

  // hold off the sender until every outstanding result has been transferred
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (board.due_dates.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic pick_valid_date(output int unsigned y, output int unsigned m,
                                 output int unsigned d);
    int unsigned roll;
    int unsigned span;
    roll = $urandom_range(9);
    if (roll < 4)       y = $urandom_range(YEAR_LIMIT, 1);
    else if (roll == 4) y = EDGE_YEARS[$urandom_range(14)];
    else if (roll == 5) y = $urandom_range(1590, 1575);
    else if (roll == 6) y = $urandom_range(CUTOVER_YEAR - 1, 1);
    else if (roll == 7) y = $urandom_range(2400, CUTOVER_YEAR + 1);
    else if (roll == 8) y = $urandom_range(YEAR_LIMIT, YEAR_LIMIT - 9);
    else                y = $urandom_range(12, 1);
    if (y == CUTOVER_YEAR && $urandom_range(2) == 0) m = MONTH_OCT;
    else m = $urandom_range(12, 1);
    span = month_span(y, m);
    roll = $urandom_range(3);
    if (roll == 0)      d = 1;
    else if (roll == 1) d = span;
    else                d = $urandom_range(span, 1);
    if (y == CUTOVER_YEAR && m == MONTH_OCT && d >= GAP_FIRST_DAY && d <= GAP_LAST_DAY)
      d = $urandom_range(1) ? DAY_BEFORE_GAP : DAY_AFTER_GAP;
  endtask

  task automatic pick_broken_date(output int unsigned y, output int unsigned m,
                                  output int unsigned d);
    int unsigned span;
    pick_valid_date(y, m, d);
    span = month_span(y, m);
    case ($urandom_range(5))
      0: y = 0;
      1: y = $urandom_range(16383, YEAR_LIMIT + 1);
      2: m = $urandom_range(1) ? 0 : $urandom_range(15, 13);
      3: d = 0;
      4: begin
        if (span < 31) d = $urandom_range(31, span + 1);
        else m = 0;
      end
      default: begin
        y = CUTOVER_YEAR;
        m = MONTH_OCT;
        d = $urandom_range(GAP_LAST_DAY, GAP_FIRST_DAY);
      end
    endcase
  endtask

  task automatic run_directed();
    send_step(KIND_NEXT);
    send_step(KIND_PREV);
    send_step(KIND_PREV);
    send_cmd(KIND_DIFF, YEAR_LIMIT, MONTH_DEC, DEC_LAST_DAY);
    send_cmd(KIND_LOAD, YEAR_LIMIT, MONTH_DEC, DEC_LAST_DAY);
    send_cmd(KIND_DIFF, 1, MONTH_JAN, DAY_FIRST);
    send_step(KIND_NEXT);
    send_cmd(KIND_LOAD, CUTOVER_YEAR, MONTH_OCT, DAY_BEFORE_GAP);
    send_step(KIND_NEXT);
    send_step(KIND_PREV);
    send_cmd(KIND_LOAD, CUTOVER_YEAR, MONTH_OCT, GAP_FIRST_DAY);
    send_cmd(KIND_LOAD, CUTOVER_YEAR, MONTH_OCT, GAP_LAST_DAY);
    send_cmd(KIND_LOAD, CUTOVER_YEAR, MONTH_OCT, DAY_AFTER_GAP);
    send_cmd(KIND_DIFF, CUTOVER_YEAR, MONTH_OCT, DAY_BEFORE_GAP);
    send_cmd(KIND_LOAD, 1900, MONTH_FEB, 29);
    send_cmd(KIND_LOAD, 1500, MONTH_FEB, 29);
    send_step(KIND_NEXT);
    send_cmd(KIND_LOAD, 2000, MONTH_JAN, DAY_FIRST);
    send_step(KIND_PREV);
    send_cmd(KIND_LOAD, 0, 5, 5);
    send_cmd(KIND_LOAD, 16383, 15, 31);
    send_cmd(KIND_LOAD, 2001, 4, 31);
    send_cmd(KIND_LOAD, 2001, 13, DAY_FIRST);
    send_cmd(KIND_DIFF, 2024, 0, 10);
    send_cmd(KIND_LOAD, 2000, 3, DAY_FIRST);
    send_step(KIND_PREV);
    send_cmd(KIND_LOAD, CUTOVER_YEAR + 1, MONTH_JAN, DAY_FIRST);
    send_step(KIND_PREV);
  endtask

  task automatic run_random(int unsigned count);
    int unsigned sent;
    int unsigned roll;
    int unsigned steps;
    int unsigned y;
    int unsigned m;
    int unsigned d;
    kind_t       dir;
    sent = 0;
    while (sent < count) begin
      roll = $urandom_range(99);
      if (roll < 30) begin
        pick_valid_date(y, m, d);
        send_cmd(KIND_LOAD, y, m, d);
        steps = $urandom_range(12, 1);
        dir = $urandom_range(1) ? KIND_NEXT : KIND_PREV;
        repeat (steps) begin
          if ($urandom_range(5) == 0) send_step($urandom_range(1) ? KIND_NEXT : KIND_PREV);
          else send_step(dir);
        end
        sent += steps + 1;
      end else if (roll < 50) begin
        pick_valid_date(y, m, d);
        send_cmd(KIND_DIFF, y, m, d);
        sent++;
      end else if (roll < 65) begin
        send_step($urandom_range(1) ? KIND_NEXT : KIND_PREV);
        sent++;
      end else if (roll < 75) begin
        steps = $urandom_range(8, 1);
        case ($urandom_range(3))
          0: begin
            send_cmd(KIND_LOAD, YEAR_LIMIT, MONTH_DEC, 31 - $urandom_range(3));
            dir = KIND_NEXT;
          end
          1: begin
            send_cmd(KIND_LOAD, 1, MONTH_JAN, $urandom_range(4, 1));
            dir = KIND_PREV;
          end
          2: begin
            send_cmd(KIND_LOAD, CUTOVER_YEAR, MONTH_OCT, $urandom_range(4, 1));
            dir = KIND_NEXT;
          end
          default: begin
            send_cmd(KIND_LOAD, CUTOVER_YEAR, MONTH_OCT, $urandom_range(20, 15));
            dir = KIND_PREV;
          end
        endcase
        repeat (steps) send_step(dir);
        sent += steps + 1;
      end else if (roll < 85) begin
        pick_broken_date(y, m, d);
        send_cmd($urandom_range(1) ? KIND_LOAD : KIND_DIFF, y, m, d);
        sent++;
      end else if (roll < 95) begin
        send_cmd(kind_t'($urandom_range(3)), $urandom_range(16383), $urandom_range(15),
                 $urandom_range(31));
        sent++;
      end else begin
        pick_valid_date(y, m, d);
        send_cmd(KIND_LOAD, y, m, d);
        sent++;
      end
    end
  endtask

  initial begin
    int unsigned phase;
    int unsigned leftover;
    board          = new();
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_kind        = KIND_LOAD;
    in_year_in     = '0;
    in_month_in    = '0;
    in_day_in      = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    for (phase = 0; phase < 4; phase++) begin
      send_idle_pct  = SEND_IDLE[phase];
      recv_stall_pct = RECV_STALL[phase];
      if (phase == 0) run_directed();
      run_random(PHASE_ITEMS);
      drain();
    end
    recv_stall_pct = 0;
    repeat (TAIL_CYCLES) @(posedge clk);
    leftover = board.due_dates.size();
    if (leftover != 0) $display("%0d results never arrived", leftover);
    $display("covered %0d loads, %0d forward steps, %0d back steps, %0d differences",
             board.kind_total[KIND_LOAD], board.kind_total[KIND_NEXT],
             board.kind_total[KIND_PREV], board.kind_total[KIND_DIFF]);
    $display("%0d results checked, %0d refused commands, 4 idle/stall phases",
             board.checked, board.refused);
    if (board.faults == 0 && leftover == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end
endmodule
